[design/salc_pkg.sv]
// Shared types, geometry constants and helpers for the set-associative LRU cache.
package salc_pkg;

    localparam int SETS    = 64;
    localparam int WAYS    = 4;
    localparam int WPB     = 8;
    localparam int SET_W   = 6;
    localparam int WAY_W   = 2;
    localparam int OFF_W   = 3;
    localparam int AGE_W   = 2;
    localparam int TAG_W   = 21;
    localparam int IDX_W   = SET_W + OFF_W;
    localparam int OFF_LSB = 2;
    localparam int SET_LSB = OFF_LSB + OFF_W;
    localparam int TAG_LSB = SET_LSB + SET_W;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;

    localparam logic [1:0] MODE_RO = 2'd0;
    localparam logic [1:0] MODE_WT = 2'd1;
    localparam logic [1:0] MODE_WB = 2'd2;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FILL  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        K_READ  = 3'd0,
        K_WDONE = 3'd1,
        K_BREQ  = 3'd2,
        K_VICT  = 3'd3,
        K_WTHRU = 3'd4,
        K_BUSY  = 3'd5
    } t_kind;

    typedef struct packed {
        t_op         op;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] mask;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic [31:0] mask;
        logic        hit;
        logic        last;
    } t_rsp;

    function automatic logic [31:0] merge(input logic [31:0] old_w, input logic [31:0] dat,
                                          input logic [31:0] msk);
        return (dat & msk) | (old_w & ~msk);
    endfunction

    function automatic t_rsp mk_rsp(input t_kind k, input logic [31:0] a, input logic [31:0] d,
                                    input logic [31:0] m, input logic h, input logic l);
        t_rsp r;
        r.kind = k;
        r.addr = a;
        r.data = d;
        r.mask = m;
        r.hit  = h;
        r.last = l;
        return r;
    endfunction

endpackage

[design/salc_if.sv]
// Request and response channel interfaces of the cache.
interface salc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [31:0] data_in;
    logic [31:0] bit_mask;

    modport source(output valid, req_type, address, data_in, bit_mask, input ready);
    modport sink(input valid, req_type, address, data_in, bit_mask, output ready);
endinterface

interface salc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] out_address;
    logic [31:0] out_data;
    logic [31:0] out_mask;
    logic        was_hit;
    logic        last;

    modport source(output valid, kind, out_address, out_data, out_mask, was_hit, last,
                   input ready);
    modport sink(input valid, kind, out_address, out_data, out_mask, was_hit, last,
                 output ready);
endinterface

[design/set_assoc_lru_cache.sv]
// An access leaves the queue into S_LOOK; a write-through write then also passes S_WDONE.
// A miss emits each word of a dirty victim via S_EV_RD and S_EV_OUT, then the block request.
// Each fill transaction is written in S_IDLE; the last one passes S_FRD and S_FCMP to finish.
// One access is in the back end at a time; the front end and queue keep accepting until the queue is full.
// Reset is synchronous and active low: all lines invalid, LRU ages equal to way numbers,
// write mode set to write-through; no clearing pass is needed.
module set_assoc_lru_cache #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    salc_in_if.sink    i_req,
    salc_out_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    logic             r_write_mode;
    logic [1:0]       r_mode;
    logic             w_full;
    logic             w_push;
    logic             w_pop;
    logic             w_head_valid;
    salc_pkg::t_entry w_entry;
    salc_pkg::t_entry w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= salc_pkg::MODE_WT;
            r_write_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode       <= i_cfg_data;
            r_write_mode <= 1'b1;
        end
    end

    salc_front u_front (
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    salc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_entry),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    salc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_write_mode (r_mode),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_rsp        (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.kind <= 3'd5))
        else $error("response kind out of range");

    a_thru_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.kind == salc_pkg::K_WTHRU) |-> !o_rsp.last)
        else $error("write-through word marked last");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.kind == salc_pkg::K_BUSY || o_rsp.kind == salc_pkg::K_BREQ
         || o_rsp.kind == salc_pkg::K_WDONE || o_rsp.kind == salc_pkg::K_READ))
        |-> o_rsp.last)
        else $error("final response not marked last");

    a_cfg_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_write_mode && r_mode == $past(i_cfg_data)))
        else $error("configuration write lost");
`endif

endmodule

[design/salc_front.sv]
// Front end: accepts request transactions, drops reserved types and classifies the rest.
module salc_front (
    salc_in_if.sink          i_req,
    input  logic             i_full,
    output logic             o_push,
    output salc_pkg::t_entry o_entry
);

    logic w_known;

    assign i_req.ready = !i_full;

    always_comb begin
        w_known       = 1'b1;
        o_entry.op    = salc_pkg::OP_READ;
        o_entry.addr  = i_req.address;
        o_entry.data  = i_req.data_in;
        o_entry.mask  = i_req.bit_mask;
        case (i_req.req_type)
            salc_pkg::REQ_READ:  o_entry.op = salc_pkg::OP_READ;
            salc_pkg::REQ_WRITE: o_entry.op = salc_pkg::OP_WRITE;
            salc_pkg::REQ_FILL:  o_entry.op = salc_pkg::OP_FILL;
            default:             w_known = 1'b0;
        endcase
    end

    assign o_push = i_req.valid && !i_full && w_known;

endmodule

[design/salc_queue.sv]
// Short queue between the front end and the back end.
module salc_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  salc_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_head_valid,
    output salc_pkg::t_entry o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    salc_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

[design/salc_back.sv]
// Back end: tag lookup, LRU, line storage, miss handling and the response register.
module salc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_write_mode,
    input  logic             i_head_valid,
    input  salc_pkg::t_entry i_head,
    output logic             o_pop,
    salc_out_if.source       o_rsp
);

    localparam int SETS  = salc_pkg::SETS;
    localparam int WAYS  = salc_pkg::WAYS;
    localparam int WPB   = salc_pkg::WPB;
    localparam int SET_W = salc_pkg::SET_W;
    localparam int WAY_W = salc_pkg::WAY_W;
    localparam int OFF_W = salc_pkg::OFF_W;
    localparam int AGE_W = salc_pkg::AGE_W;
    localparam int TAG_W = salc_pkg::TAG_W;
    localparam int IDX_W = salc_pkg::IDX_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOK   = 8'b0000_0010,
        S_WDONE  = 8'b0000_0100,
        S_EV_RD  = 8'b0000_1000,
        S_EV_OUT = 8'b0001_0000,
        S_REQ    = 8'b0010_0000,
        S_FRD    = 8'b0100_0000,
        S_FCMP   = 8'b1000_0000
    } t_state;

    logic [TAG_W-1:0] r_tag_mem [WAYS][SETS];
    logic [31:0]      r_dat_mem [WAYS][SETS*WPB];
    logic [TAG_W-1:0] r_tag_rd  [WAYS];
    logic [31:0]      r_dat_rd  [WAYS];
    logic [WAYS-1:0]  r_valid   [SETS];
    logic [WAYS-1:0]  r_dirty   [SETS];
    logic [AGE_W-1:0] r_age     [SETS][WAYS];

    t_state           r_state, n_state;
    logic             r_out_valid, n_out_valid;
    salc_pkg::t_rsp   r_out, n_out;
    salc_pkg::t_op    r_op, n_op;
    logic [31:0]      r_addr, n_addr;
    logic [31:0]      r_data, n_data;
    logic [31:0]      r_mask, n_mask;
    logic             r_hit, n_hit;
    logic             r_pend, n_pend;
    logic             r_pwrite, n_pwrite;
    logic [31:0]      r_paddr, n_paddr;
    logic [31:0]      r_pdata, n_pdata;
    logic [31:0]      r_pmask, n_pmask;
    logic [OFF_W-1:0] r_fcnt, n_fcnt;
    logic [WAY_W-1:0] r_victim, n_victim;
    logic [TAG_W-1:0] r_vtag, n_vtag;
    logic [OFF_W-1:0] r_idx, n_idx;

    logic             w_can_emit;
    logic [SET_W-1:0] w_cset, w_pset;
    logic [TAG_W-1:0] w_ctag, w_ptag;
    logic [OFF_W-1:0] w_coff, w_poff;
    logic             w_hit;
    logic [WAY_W-1:0] w_hway, w_vic;
    logic             w_vic_found;
    logic [1:0]       w_mode;

    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_idx;
    logic             w_wr_en;
    logic [WAY_W-1:0] w_wr_way;
    logic [IDX_W-1:0] w_wr_idx;
    logic [31:0]      w_wr_data;
    logic             w_tag_we;
    logic             w_vd_we;
    logic [SET_W-1:0] w_vd_set;
    logic [WAY_W-1:0] w_vd_way;
    logic             w_vd_valid, w_vd_dirty;
    logic             w_touch;
    logic [SET_W-1:0] w_t_set;
    logic [WAY_W-1:0] w_t_way;

    assign w_can_emit = !r_out_valid || o_rsp.ready;
    assign w_cset = r_addr[salc_pkg::SET_LSB +: SET_W];
    assign w_ctag = r_addr[salc_pkg::TAG_LSB +: TAG_W];
    assign w_coff = r_addr[salc_pkg::OFF_LSB +: OFF_W];
    assign w_pset = r_paddr[salc_pkg::SET_LSB +: SET_W];
    assign w_ptag = r_paddr[salc_pkg::TAG_LSB +: TAG_W];
    assign w_poff = r_paddr[salc_pkg::OFF_LSB +: OFF_W];
    assign w_mode = (i_write_mode == MODE_RO_OR_RSVD()) ? salc_pkg::MODE_RO : i_write_mode;

    function automatic logic [1:0] MODE_RO_OR_RSVD();
        return 2'd3;
    endfunction

    always_comb begin
        w_hit       = 1'b0;
        w_hway      = '0;
        w_vic_found = 1'b0;
        w_vic       = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!w_hit && r_valid[w_cset][w] && r_tag_rd[w] == w_ctag) begin
                w_hit  = 1'b1;
                w_hway = WAY_W'(w);
            end
            if (!w_vic_found && !r_valid[w_cset][w]) begin
                w_vic_found = 1'b1;
                w_vic       = WAY_W'(w);
            end
        end
        if (!w_vic_found) begin
            for (int w = 1; w < WAYS; w++) begin
                if (r_age[w_cset][w] > r_age[w_cset][w_vic]) begin
                    w_vic = WAY_W'(w);
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_out      = r_out;
        n_op       = r_op;
        n_addr     = r_addr;
        n_data     = r_data;
        n_mask     = r_mask;
        n_hit      = r_hit;
        n_pend     = r_pend;
        n_pwrite   = r_pwrite;
        n_paddr    = r_paddr;
        n_pdata    = r_pdata;
        n_pmask    = r_pmask;
        n_fcnt     = r_fcnt;
        n_victim   = r_victim;
        n_vtag     = r_vtag;
        n_idx      = r_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        o_pop      = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_idx   = '0;
        w_wr_en    = 1'b0;
        w_wr_way   = '0;
        w_wr_idx   = '0;
        w_wr_data  = '0;
        w_tag_we   = 1'b0;
        w_vd_we    = 1'b0;
        w_vd_set   = w_cset;
        w_vd_way   = '0;
        w_vd_valid = 1'b0;
        w_vd_dirty = 1'b0;
        w_touch    = 1'b0;
        w_t_set    = w_cset;
        w_t_way    = w_hway;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid && w_can_emit) begin
                    o_pop  = 1'b1;
                    n_op   = i_head.op;
                    n_addr = i_head.addr;
                    n_data = i_head.data;
                    n_mask = i_head.mask;
                    if (i_head.op == salc_pkg::OP_FILL) begin
                        if (r_pend) begin
                            w_wr_en   = 1'b1;
                            w_wr_way  = r_victim;
                            w_wr_idx  = {w_pset, r_fcnt};
                            w_wr_data = i_head.data;
                            if (r_fcnt == OFF_W'(WPB - 1)) begin
                                n_state = S_FRD;
                            end else begin
                                n_fcnt = r_fcnt + 1'b1;
                            end
                        end
                    end else if (r_pend) begin
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_BUSY, i_head.addr, '0, '0,
                                                 1'b0, 1'b1);
                        n_out_valid = 1'b1;
                    end else begin
                        w_rd_en  = 1'b1;
                        w_rd_idx = {i_head.addr[salc_pkg::SET_LSB +: SET_W],
                                    i_head.addr[salc_pkg::OFF_LSB +: OFF_W]};
                        n_state  = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (w_can_emit) begin
                    n_state = S_IDLE;
                    if (r_op == salc_pkg::OP_READ && w_hit) begin
                        w_touch = 1'b1;
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_READ, r_addr, r_dat_rd[w_hway],
                                                 '0, 1'b1, 1'b1);
                        n_out_valid = 1'b1;
                    end else if (r_op != salc_pkg::OP_READ && w_mode == salc_pkg::MODE_RO) begin
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_WDONE, r_addr, '0, '0,
                                                 w_hit, 1'b1);
                        n_out_valid = 1'b1;
                    end else if (r_op != salc_pkg::OP_READ && w_mode == salc_pkg::MODE_WT) begin
                        if (w_hit) begin
                            w_touch   = 1'b1;
                            w_wr_en   = 1'b1;
                            w_wr_way  = w_hway;
                            w_wr_idx  = {w_cset, w_coff};
                            w_wr_data = salc_pkg::merge(r_dat_rd[w_hway], r_data, r_mask);
                        end
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_WTHRU, {r_addr[31:2], 2'b00},
                                                 r_data, r_mask, w_hit, 1'b0);
                        n_out_valid = 1'b1;
                        n_hit   = w_hit;
                        n_state = S_WDONE;
                    end else if (w_hit) begin
                        w_touch    = 1'b1;
                        w_wr_en    = 1'b1;
                        w_wr_way   = w_hway;
                        w_wr_idx   = {w_cset, w_coff};
                        w_wr_data  = salc_pkg::merge(r_dat_rd[w_hway], r_data, r_mask);
                        w_vd_we    = 1'b1;
                        w_vd_way   = w_hway;
                        w_vd_valid = 1'b1;
                        w_vd_dirty = 1'b1;
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_WDONE, r_addr, '0, '0,
                                                 1'b1, 1'b1);
                        n_out_valid = 1'b1;
                    end else begin
                        n_victim = w_vic;
                        n_vtag   = r_tag_rd[w_vic];
                        n_fcnt   = '0;
                        n_idx    = '0;
                        n_pend   = 1'b1;
                        n_pwrite = (r_op == salc_pkg::OP_WRITE);
                        n_paddr  = r_addr;
                        n_pdata  = r_data;
                        n_pmask  = r_mask;
                        w_vd_we  = 1'b1;
                        w_vd_way = w_vic;
                        if (r_valid[w_cset][w_vic] && r_dirty[w_cset][w_vic]) begin
                            n_state = S_EV_RD;
                        end else begin
                            n_state = S_REQ;
                        end
                    end
                end
            end
            S_WDONE: begin
                if (w_can_emit) begin
                    n_out = salc_pkg::mk_rsp(salc_pkg::K_WDONE, r_addr, '0, '0, r_hit, 1'b1);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EV_RD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = {w_pset, r_idx};
                n_state  = S_EV_OUT;
            end
            S_EV_OUT: begin
                if (w_can_emit) begin
                    n_out = salc_pkg::mk_rsp(salc_pkg::K_VICT, {r_vtag, w_pset, r_idx, 2'b00},
                                             r_dat_rd[r_victim], '0, 1'b0, 1'b0);
                    n_out_valid = 1'b1;
                    if (r_idx == OFF_W'(WPB - 1)) begin
                        n_state = S_REQ;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_EV_RD;
                    end
                end
            end
            S_REQ: begin
                if (w_can_emit) begin
                    n_out = salc_pkg::mk_rsp(salc_pkg::K_BREQ, {w_ptag, w_pset, {OFF_W{1'b0}},
                                             2'b00}, '0, '0, 1'b0, 1'b1);
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FRD: begin
                w_rd_en  = 1'b1;
                w_rd_idx = {w_pset, w_poff};
                n_state  = S_FCMP;
            end
            S_FCMP: begin
                if (w_can_emit) begin
                    w_tag_we   = 1'b1;
                    w_vd_we    = 1'b1;
                    w_vd_set   = w_pset;
                    w_vd_way   = r_victim;
                    w_vd_valid = 1'b1;
                    w_vd_dirty = r_pwrite;
                    w_touch    = 1'b1;
                    w_t_set    = w_pset;
                    w_t_way    = r_victim;
                    if (r_pwrite) begin
                        w_wr_en   = 1'b1;
                        w_wr_way  = r_victim;
                        w_wr_idx  = {w_pset, w_poff};
                        w_wr_data = salc_pkg::merge(r_dat_rd[r_victim], r_pdata, r_pmask);
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_WDONE, r_paddr, '0, '0,
                                                 1'b0, 1'b1);
                    end else begin
                        n_out = salc_pkg::mk_rsp(salc_pkg::K_READ, r_paddr,
                                                 r_dat_rd[r_victim], '0, 1'b0, 1'b1);
                    end
                    n_out_valid = 1'b1;
                    n_pend  = 1'b0;
                    n_fcnt  = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_fcnt      <= '0;
            r_victim    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_fcnt      <= n_fcnt;
            r_victim    <= n_victim;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_data   <= n_data;
        r_mask   <= n_mask;
        r_hit    <= n_hit;
        r_pwrite <= n_pwrite;
        r_paddr  <= n_paddr;
        r_pdata  <= n_pdata;
        r_pmask  <= n_pmask;
        r_vtag   <= n_vtag;
        r_idx    <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < WAYS; w++) begin
            if (w_rd_en) begin
                r_tag_rd[w] <= r_tag_mem[w][w_rd_idx[IDX_W-1 -: SET_W]];
                r_dat_rd[w] <= r_dat_mem[w][w_rd_idx];
            end
            if (w_wr_en && w_wr_way == WAY_W'(w)) begin
                r_dat_mem[w][w_wr_idx] <= w_wr_data;
            end
            if (w_tag_we && r_victim == WAY_W'(w)) begin
                r_tag_mem[w][w_pset] <= w_ptag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
                r_dirty[s] <= '0;
                for (int w = 0; w < WAYS; w++) begin
                    r_age[s][w] <= AGE_W'(w);
                end
            end
        end else begin
            if (w_vd_we) begin
                r_valid[w_vd_set][w_vd_way] <= w_vd_valid;
                r_dirty[w_vd_set][w_vd_way] <= w_vd_dirty;
            end
            if (w_touch) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (r_age[w_t_set][w] < r_age[w_t_set][w_t_way]) begin
                        r_age[w_t_set][w] <= r_age[w_t_set][w] + 1'b1;
                    end
                end
                r_age[w_t_set][w_t_way] <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.out_address = r_out.addr;
    assign o_rsp.out_data    = r_out.data;
    assign o_rsp.out_mask    = r_out.mask;
    assign o_rsp.was_hit     = r_out.hit;
    assign o_rsp.last        = r_out.last;

endmodule
